@@ rtl/core/arm_charge_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Arm charge sequencer assertion macros
// Shared assertion forms for the sequencer checker, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ARM_CHARGE_SEQUENCER_DEFINES_SVH
`define ARM_CHARGE_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define ACS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acs assertion failed");

// Next-cycle implication.
`define ACS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acs assertion failed");

`endif

@@ rtl/core/acs_pkg.sv @@
// ----------------------------------------------------------------------------
// Arm charge sequencer package
// Codes, reset values and the structs passed between the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CATCH_TARGET = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_TARGET = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_MS    = 2'd2;

  localparam logic [7:0]  CATCH_TARGET_RST = 8'd1;
  localparam logic [7:0]  RETRY_TARGET_RST = 8'd0;
  localparam logic [15:0] SETTLE_MS_RST    = 16'd5000;

  // Poll commands
  localparam logic [1:0] CMD_POLL  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_INIT    = 3'd1;
  localparam logic [2:0] PH_CATCH   = 3'd2;
  localparam logic [2:0] PH_CONNECT = 3'd3;
  localparam logic [2:0] PH_SETTLE  = 3'd4;
  localparam logic [2:0] PH_SWON    = 3'd5;
  localparam logic [2:0] PH_DISC    = 3'd6;
  localparam logic [2:0] PH_FINISH  = 3'd7;

  // Servo commands
  localparam logic [2:0] SERVO_NONE       = 3'd0;
  localparam logic [2:0] SERVO_CATCH_HOLD = 3'd1;
  localparam logic [2:0] SERVO_CATCH_ONCE = 3'd2;
  localparam logic [2:0] SERVO_RELEASE    = 3'd3;
  localparam logic [2:0] SERVO_USB_ON     = 3'd4;
  localparam logic [2:0] SERVO_USB_OFF    = 3'd5;

  // Switch and timer commands
  localparam logic [1:0] SW_NONE  = 2'd0;
  localparam logic [1:0] SW_ON    = 2'd1;
  localparam logic [1:0] SW_OFF   = 2'd2;
  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  typedef struct packed {
    logic [7:0]  catch_target;
    logic [7:0]  retry_target;
    logic [15:0] settle_ms;
  } acs_cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        drone_released;
    logic        drone_caught;
    logic        usb_disconnected;
    logic        usb_connected;
    logic        servo_moving;
    logic        switch_is_on;
    logic [31:0] now_ms;
  } acs_item_t;

  typedef struct packed {
    logic [2:0] servo_cmd;
    logic [1:0] switch_cmd;
    logic [1:0] timer_cmd;
    logic       done_res;
    logic [2:0] phase;
  } acs_result_t;

endpackage

`default_nettype wire

@@ rtl/core/acs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Arm charge sequencer configuration registers
// Holds catch target, retry target and settle time; one write per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acs_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [acs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [acs_pkg::CfgDataW-1:0]  cfg_data_i,
  output acs_pkg::acs_cfg_t                  cfg_o
);

  acs_pkg::acs_cfg_t cfg_q, cfg_d;
  logic              wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_index_i)
        acs_pkg::CFG_CATCH_TARGET: cfg_d.catch_target = cfg_data_i[7:0];
        acs_pkg::CFG_RETRY_TARGET: cfg_d.retry_target = cfg_data_i[7:0];
        acs_pkg::CFG_SETTLE_MS:    cfg_d.settle_ms    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.catch_target <= acs_pkg::CATCH_TARGET_RST;
      cfg_q.retry_target <= acs_pkg::RETRY_TARGET_RST;
      cfg_q.settle_ms    <= acs_pkg::SETTLE_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/acs_step.sv @@
// ----------------------------------------------------------------------------
// Arm charge sequencer step
// Phase register, counters and settle time stamp, with the logic that turns
// one poll into one set of commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acs_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_en_i,
  input  wire acs_pkg::acs_item_t  item_i,
  input  wire acs_pkg::acs_cfg_t   cfg_i,
  output acs_pkg::acs_result_t     result_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  catch_q, catch_d;
  logic [7:0]  retry_q, retry_d;
  logic [31:0] settle_q, settle_d;
  logic [7:0]  catch_base;
  logic [31:0] elapsed;
  logic        hold_catch;

  // Wrapping still time
  assign elapsed = item_i.now_ms - settle_q;

  // Init phase counts from zero within the same poll
  assign catch_base = (phase_q == acs_pkg::PH_INIT) ? 8'd0 : catch_q;
  assign hold_catch = {1'b0, cfg_i.catch_target} <= ({1'b0, catch_base} + 9'd1);

  always_comb begin
    phase_d  = phase_q;
    catch_d  = catch_q;
    retry_d  = retry_q;
    settle_d = settle_q;
    result_o = '0;

    unique case (item_i.cmd)
      acs_pkg::CMD_START: begin
        catch_d = 8'd0;
        retry_d = 8'd0;
        phase_d = acs_pkg::PH_INIT;
      end
      acs_pkg::CMD_STOP: begin
        result_o.switch_cmd = acs_pkg::SW_OFF;
        result_o.timer_cmd  = acs_pkg::TMR_STOP;
        phase_d             = acs_pkg::PH_IDLE;
      end
      acs_pkg::CMD_POLL: begin
        unique case (phase_q)
          acs_pkg::PH_IDLE: ;
          acs_pkg::PH_INIT, acs_pkg::PH_CATCH: begin
            catch_d = catch_base;
            phase_d = acs_pkg::PH_CATCH;
            if (phase_q == acs_pkg::PH_INIT) begin
              retry_d = 8'd0;
            end
            if (item_i.drone_released) begin
              result_o.servo_cmd = hold_catch ? acs_pkg::SERVO_CATCH_HOLD
                                              : acs_pkg::SERVO_CATCH_ONCE;
              catch_d = catch_base + 8'd1;
            end else if (item_i.drone_caught) begin
              if (catch_base >= cfg_i.catch_target) begin
                phase_d = acs_pkg::PH_CONNECT;
              end else begin
                result_o.servo_cmd = acs_pkg::SERVO_RELEASE;
              end
            end
          end
          acs_pkg::PH_CONNECT: begin
            if (item_i.usb_disconnected) begin
              result_o.servo_cmd = acs_pkg::SERVO_USB_ON;
            end else if (item_i.usb_connected) begin
              if (retry_q < cfg_i.retry_target) begin
                catch_d = 8'd0;
                retry_d = retry_q + 8'd1;
                phase_d = acs_pkg::PH_DISC;
              end else begin
                settle_d = item_i.now_ms;
                phase_d  = acs_pkg::PH_SETTLE;
              end
            end
          end
          acs_pkg::PH_SETTLE: begin
            if (item_i.servo_moving) begin
              settle_d = item_i.now_ms;
            end else if (elapsed > {16'd0, cfg_i.settle_ms}) begin
              phase_d = acs_pkg::PH_SWON;
            end
          end
          acs_pkg::PH_SWON: begin
            if (!item_i.switch_is_on) begin
              result_o.switch_cmd = acs_pkg::SW_ON;
              result_o.timer_cmd  = acs_pkg::TMR_START;
            end else begin
              phase_d = acs_pkg::PH_FINISH;
            end
          end
          acs_pkg::PH_DISC: begin
            if (item_i.usb_connected) begin
              result_o.servo_cmd = acs_pkg::SERVO_USB_OFF;
            end else if (item_i.usb_disconnected) begin
              phase_d = acs_pkg::PH_CATCH;
            end
          end
          acs_pkg::PH_FINISH: begin
            phase_d           = acs_pkg::PH_IDLE;
            result_o.done_res = 1'b1;
          end
        endcase
      end
      default: ;  // unused command: no commands, phase kept
    endcase

    result_o.phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= acs_pkg::PH_IDLE;
      catch_q  <= 8'd0;
      retry_q  <= 8'd0;
      settle_q <= 32'd0;
    end else if (step_en_i) begin
      phase_q  <= phase_d;
      catch_q  <= catch_d;
      retry_q  <= retry_d;
      settle_q <= settle_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/arm_charge_sequencer.sv @@
// ----------------------------------------------------------------------------
// Arm charge sequencer
// Steps a charging arm through catch, USB connect, settle and switch-on,
// one poll transaction in, one command transaction out.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       poll flags, time stamp, cmd
//   m_axis    out        m_axis_tvalid/tready       servo/switch/timer cmds
//   cfg       in         cfg_valid_i/cfg_ready_o    register index, data
//
// One poll is accepted per cycle while the result register is free or drained;
// it is captured in the input register, then stepped into the result register.
// The step logic between the two registers sets that rate: the phase and
// counters update in the same cycle the poll moves into the result register.
// Reset clears the phase, counters and valid flags; config returns to defaults.
// A stalled output holds its result; the input register keeps filling while
// the result register is free or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arm_charge_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] drone_released, [1] drone_caught, [2] usb_disconnected,
  // [3] usb_connected, [4] servo_moving, [5] switch_is_on,
  // [37:6] now_ms, [39:38] zero
  input  wire logic [acs_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [2:0] servo_cmd, [4:3] switch_cmd, [6:5] timer_cmd, [9:7] phase,
  // [15:10] zero
  output logic [acs_pkg::OutDataW-1:0]       m_axis_tdata,
  // done_res
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [acs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [acs_pkg::CfgDataW-1:0]  cfg_data_i
);

  acs_pkg::acs_cfg_t    cfg;
  acs_pkg::acs_item_t   in_item_d, in_item_q;
  acs_pkg::acs_result_t step_res, out_res_q;
  logic                 in_valid_q, in_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 s_accept;
  logic                 advance;

  acs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Unpack the poll
  always_comb begin
    in_item_d.cmd              = s_axis_tuser;
    in_item_d.drone_released   = s_axis_tdata[0];
    in_item_d.drone_caught     = s_axis_tdata[1];
    in_item_d.usb_disconnected = s_axis_tdata[2];
    in_item_d.usb_connected    = s_axis_tdata[3];
    in_item_d.servo_moving     = s_axis_tdata[4];
    in_item_d.switch_is_on     = s_axis_tdata[5];
    in_item_d.now_ms           = s_axis_tdata[37:6];
  end

  // Advance when the result register is empty or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  acs_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_res_q.done_res;
  assign m_axis_tdata  = {6'd0, out_res_q.phase, out_res_q.timer_cmd,
                          out_res_q.switch_cmd, out_res_q.servo_cmd};

endmodule

`default_nettype wire

@@ rtl/core/acs_checker.sv @@
// ----------------------------------------------------------------------------
// Arm charge sequencer checker
// Port-level checks on the command stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arm_charge_sequencer_defines.svh"

module acs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [acs_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire logic                          m_axis_tlast
);

  // Finishing poll returns to idle with no commands
  `ACS_ASSERT_NOW(a_done_idle, m_axis_tvalid && m_axis_tlast,
                  m_axis_tdata[9:7] == acs_pkg::PH_IDLE &&
                  m_axis_tdata[2:0] == acs_pkg::SERVO_NONE &&
                  m_axis_tdata[4:3] == acs_pkg::SW_NONE)

  // Switch on always comes with timer start while in switch-on phase
  `ACS_ASSERT_NOW(a_sw_on_timer, m_axis_tvalid && m_axis_tdata[4:3] == acs_pkg::SW_ON,
                  m_axis_tdata[6:5] == acs_pkg::TMR_START &&
                  m_axis_tdata[9:7] == acs_pkg::PH_SWON)

  // Switch off only from a stop, which lands in idle
  `ACS_ASSERT_NOW(a_sw_off_stop, m_axis_tvalid && m_axis_tdata[4:3] == acs_pkg::SW_OFF,
                  m_axis_tdata[6:5] == acs_pkg::TMR_STOP &&
                  m_axis_tdata[9:7] == acs_pkg::PH_IDLE)

  // A stalled result holds
  `ACS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind arm_charge_sequencer acs_checker u_acs_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Arm charge sequencer testbench
// Sends poll transactions, predicts the command transaction of each poll from a
// local model of the sequencer and compares it field by field. Directed
// sequences come first, then guided random sequences over a sweep of register
// settings and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import acs_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned LONG_HOLD   = 200;

  // Status flag masks in tdata order
  localparam logic [5:0] F_REL  = 6'b000001;
  localparam logic [5:0] F_CAU  = 6'b000010;
  localparam logic [5:0] F_UOFF = 6'b000100;
  localparam logic [5:0] F_UON  = 6'b001000;
  localparam logic [5:0] F_MOV  = 6'b010000;
  localparam logic [5:0] F_SWON = 6'b100000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [5:0] status flags, [37:6] now_ms, [39:38] zero
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // [1:0] cmd
  logic [1:0]          s_axis_tuser  = CMD_POLL;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [2:0] servo, [4:3] switch, [6:5] timer, [9:7] phase, [15:10] zero
  logic [OutDataW-1:0] m_axis_tdata;
  // done_res
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = CFG_CATCH_TARGET;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Local copy of the sequencer state and registers
  logic [2:0]  ph          = PH_IDLE;
  logic [7:0]  catches     = '0;
  logic [7:0]  retries     = '0;
  logic [31:0] still_since = '0;
  logic [7:0]  tgt_catch   = CATCH_TARGET_RST;
  logic [7:0]  tgt_retry   = RETRY_TARGET_RST;
  logic [15:0] settle_lim  = SETTLE_MS_RST;

  acs_result_t expected_cmds[$];
  logic [31:0] clock_ms     = '0;
  bit          no_gaps      = 1'b0;
  int          hold_cycles  = 0;
  int          fail_count   = 0;
  int unsigned quiet_cycles = 0;

  arm_charge_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Advance the local sequencer by one poll and return its commands
  function automatic acs_result_t sequence_step(acs_item_t p);
    acs_result_t r;
    logic [31:0] elapsed;
    r = '0;
    case (p.cmd)
      CMD_START: begin
        catches = '0;
        retries = '0;
        ph      = PH_INIT;
      end
      CMD_STOP: begin
        r.switch_cmd = SW_OFF;
        r.timer_cmd  = TMR_STOP;
        ph           = PH_IDLE;
      end
      CMD_POLL: begin
        case (ph)
          PH_IDLE: ;
          PH_INIT, PH_CATCH: begin
            if (ph == PH_INIT) begin
              catches = '0;
              retries = '0;
              ph      = PH_CATCH;
            end
            if (p.drone_released) begin
              // compare one bit wider so the count plus one cannot wrap
              r.servo_cmd = ({1'b0, tgt_catch} <= {1'b0, catches} + 9'd1) ?
                            SERVO_CATCH_HOLD : SERVO_CATCH_ONCE;
              catches = catches + 8'd1;
            end else if (p.drone_caught) begin
              if (catches >= tgt_catch) ph = PH_CONNECT;
              else r.servo_cmd = SERVO_RELEASE;
            end
          end
          PH_CONNECT: begin
            if (p.usb_disconnected) begin
              r.servo_cmd = SERVO_USB_ON;
            end else if (p.usb_connected) begin
              if (retries < tgt_retry) begin
                catches = '0;
                retries = retries + 8'd1;
                ph      = PH_DISC;
              end else begin
                still_since = p.now_ms;
                ph          = PH_SETTLE;
              end
            end
          end
          PH_SETTLE: begin
            elapsed = p.now_ms - still_since;
            if (p.servo_moving) still_since = p.now_ms;
            else if (elapsed > {16'd0, settle_lim}) ph = PH_SWON;
          end
          PH_SWON: begin
            if (!p.switch_is_on) begin
              r.switch_cmd = SW_ON;
              r.timer_cmd  = TMR_START;
            end else begin
              ph = PH_FINISH;
            end
          end
          PH_DISC: begin
            if (p.usb_connected) r.servo_cmd = SERVO_USB_OFF;
            else if (p.usb_disconnected) ph = PH_CATCH;
          end
          default: begin
            ph         = PH_IDLE;
            r.done_res = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
    r.phase = ph;
    return r;
  endfunction

  function automatic acs_item_t make_poll(logic [1:0] cmd, logic [5:0] flags,
                                          logic [31:0] now);
    acs_item_t p;
    p.cmd = cmd;
    {p.switch_is_on, p.servo_moving, p.usb_connected, p.usb_disconnected,
     p.drone_caught, p.drone_released} = flags;
    p.now_ms = now;
    return p;
  endfunction

  // Pick a poll that moves the current phase forward, with some noise mixed in
  function automatic acs_item_t guided_poll();
    acs_item_t p;
    int unsigned pick;
    clock_ms = clock_ms + $urandom_range(0, settle_lim / 4 + 16);
    p = make_poll(CMD_POLL, '0, clock_ms);
    if (chance(10)) begin
      p = make_poll(2'($urandom_range(0, 3)), 6'($urandom()),
                    chance(50) ? $urandom() : clock_ms);
      return p;
    end
    case (ph)
      PH_IDLE: if (chance(80)) p.cmd = CMD_START;
      PH_INIT, PH_CATCH: begin
        if (chance(50)) begin
          p.drone_released = 1'b1;
          p.drone_caught   = chance(20);
        end else begin
          p.drone_caught = chance(95);
        end
      end
      PH_CONNECT: begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          p.usb_disconnected = 1'b1;
          p.usb_connected    = chance(25);
        end else if (pick < 9) begin
          p.usb_connected = 1'b1;
        end
      end
      PH_SETTLE: begin
        p.servo_moving = chance(30);
        // land right on the settle boundary now and then
        if (!p.servo_moving && chance(25)) begin
          p.now_ms = still_since + 32'(settle_lim) + 32'($urandom_range(0, 1));
          clock_ms = p.now_ms;
        end
      end
      PH_SWON: p.switch_is_on = chance(50);
      PH_DISC: begin
        if (chance(50)) begin
          p.usb_connected    = 1'b1;
          p.usb_disconnected = chance(25);
        end else begin
          p.usb_disconnected = 1'b1;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic issue_poll(input acs_item_t p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.cmd;
    s_axis_tdata  <= {2'b00, p.now_ms, p.switch_is_on, p.servo_moving, p.usb_connected,
                      p.usb_disconnected, p.drone_caught, p.drone_released};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_cmds.push_back(sequence_step(p));
  endtask

  task automatic send(input logic [1:0] cmd, input logic [5:0] flags,
                      input logic [31:0] now);
    issue_poll(make_poll(cmd, flags, now));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_cmds.size() != 0) @(posedge clk_i);
  endtask

  // Write all three registers back to back; junk in the unused upper byte
  task automatic program_regs(input logic [7:0] ct, input logic [7:0] rt,
                              input logic [15:0] sm);
    logic [CfgIdxW-1:0]  regs [3] = '{CFG_CATCH_TARGET, CFG_RETRY_TARGET, CFG_SETTLE_MS};
    logic [CfgDataW-1:0] vals [3];
    vals[0] = {8'($urandom()), ct};
    vals[1] = {8'($urandom()), rt};
    vals[2] = sm;
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    tgt_catch  = ct;
    tgt_retry  = rt;
    settle_lim = sm;
  endtask

  // One full pass on the reset settings, with time wrap and ignored commands
  task automatic test_directed_default();
    send(CMD_POLL, F_REL | F_CAU | F_UOFF | F_UON | F_MOV | F_SWON, 32'd0);
    send(CMD_UNUSED, F_REL | F_CAU | F_UOFF | F_UON | F_MOV | F_SWON, 32'hFFFF_FFFF);
    send(CMD_START, '0, 32'd0);
    send(CMD_POLL, F_REL | F_CAU, 32'd10);
    send(CMD_POLL, F_CAU, 32'd20);
    send(CMD_POLL, F_UOFF | F_UON, 32'd30);
    send(CMD_POLL, F_UON, 32'hFFFF_FF00);
    send(CMD_POLL, F_MOV, 32'hFFFF_FFFF);
    send(CMD_POLL, '0, 32'd4999);
    send(CMD_POLL, '0, 32'd5000);
    send(CMD_POLL, '0, 32'd5001);
    send(CMD_UNUSED, '0, 32'd5002);
    send(CMD_POLL, F_SWON, 32'd5003);
    send(CMD_POLL, '0, 32'd5004);
    send(CMD_START, '0, 32'd5005);
    send(CMD_POLL, F_REL, 32'd5006);
    send(CMD_STOP, F_SWON, 32'd5007);
  endtask

  // Two catches and one USB retry with a zero settle time
  task automatic test_directed_retry();
    wait_drain();
    program_regs(8'd2, 8'd1, 16'd0);
    send(CMD_START, '0, 32'd0);
    send(CMD_POLL, F_REL, 32'd1);
    send(CMD_POLL, F_CAU, 32'd2);
    send(CMD_POLL, F_REL, 32'd3);
    send(CMD_POLL, F_CAU, 32'd4);
    send(CMD_POLL, F_UON, 32'd5);
    send(CMD_POLL, F_UON | F_UOFF, 32'd6);
    send(CMD_POLL, F_UOFF, 32'd7);
    send(CMD_POLL, F_CAU, 32'd8);
    send(CMD_STOP, '0, 32'd9);
  endtask

  // Release more than 256 times in a row so the catch count wraps
  task automatic test_catch_wrap();
    wait_drain();
    program_regs(8'd255, 8'd0, 16'd1);
    send(CMD_START, '0, clock_ms);
    repeat (258) send(CMD_POLL, F_REL, clock_ms);
    send(CMD_POLL, F_CAU, clock_ms);
    send(CMD_STOP, '0, clock_ms);
  endtask

  task automatic test_config_sweep();
    logic [7:0]  ct;
    logic [7:0]  rt;
    logic [15:0] sm;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin ct = 8'd0;   rt = 8'd0;   sm = 16'd0;     end
        1: begin ct = 8'd1;   rt = 8'd1;   sm = 16'hFFFF;  end
        2: begin ct = 8'd255; rt = 8'd255; sm = 16'd1;     end
        3: begin ct = 8'd0;   rt = 8'd255; sm = 16'd100;   end
        4: begin ct = 8'd3;   rt = 8'd2;   sm = 16'($urandom_range(0, 2000)); end
        5: begin ct = 8'd2;   rt = 8'd0;   sm = 16'd1;     end
        default: begin
          ct = 8'($urandom_range(0, 5));
          rt = 8'($urandom_range(0, 3));
          sm = 16'($urandom_range(0, 3000));
        end
      endcase
      wait_drain();
      program_regs(ct, rt, sm);
      // take some settings without any idle cycles on either side
      no_gaps = (k == 2 || k == 5);
      if (chance(50)) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
      repeat (175) issue_poll(guided_poll());
    end
    no_gaps = 1'b0;
  endtask

  // Hold the output off while polls keep coming, so the input stalls
  task automatic test_backpressure();
    wait_drain();
    hold_cycles = LONG_HOLD;
    no_gaps     = 1'b1;
    repeat (40) issue_poll(guided_poll());
    no_gaps     = 1'b0;
  endtask

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    acs_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_cmds.size() == 0) begin
        $error("command transaction with no poll pending: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_cmds.pop_front();
        compare_field("servo_cmd", want.servo_cmd, m_axis_tdata[2:0]);
        compare_field("switch_cmd", want.switch_cmd, m_axis_tdata[4:3]);
        compare_field("timer_cmd", want.timer_cmd, m_axis_tdata[6:5]);
        compare_field("phase", want.phase, m_axis_tdata[9:7]);
        compare_field("tdata padding", 0, m_axis_tdata[15:10]);
        compare_field("done_res", want.done_res, m_axis_tlast);
      end
    end
  end

  initial begin : drain_results
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("arm_charge_sequencer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_default();
    test_directed_retry();
    test_catch_wrap();
    test_config_sweep();
    test_backpressure();
    wait_drain();
    // two register stages; leave room for a stray extra transaction
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("arm_charge_sequencer test passed");
    end else begin
      $display("arm_charge_sequencer test failed");
    end
    $finish;
  end

endmodule
